@@ rtl/wcpd_pkg.sv @@
// shared types and constants of the waveform column peak decimator
package wcpd_pkg;

  // default values of the top level parameters
  localparam int SAMPLE_BITS_DEFAULT  = 16;
  localparam int COLUMN_BITS_DEFAULT  = 14;
  localparam int MAX_CHANNELS_DEFAULT = 8;

  // register field widths
  localparam int FRAME_BITS   = 24;
  localparam int COLCNT_BITS  = 15;
  localparam int CHCNT_BITS   = 4;
  localparam int HEIGHT_BITS  = 13;
  localparam int CH_FIELD_W   = 5;
  localparam int Y_BITS       = 13;

  // boundary accumulators wrap at this width
  localparam int ACC_BITS     = 38;

  localparam int MAX_RESULTS  = 64;
  localparam int RUN_CNT_BITS = $clog2(MAX_RESULTS + 1);
  localparam int MAX_COLUMNS  = 16384;
  localparam int MAX_HEIGHT   = 4096;

  // apb register map
  localparam int ADDR_BITS    = 4;
  localparam int DATA_BITS    = 32;

  localparam int QUEUE_DEPTH  = 4;

  localparam logic [FRAME_BITS-1:0]  FRAMES_RESET   = FRAME_BITS'(1);
  localparam logic [COLCNT_BITS-1:0] COLUMNS_RESET  = COLCNT_BITS'(2000);
  localparam logic [CHCNT_BITS-1:0]  CHANNELS_RESET = CHCNT_BITS'(1);
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET   = HEIGHT_BITS'(200);

  typedef enum logic [1:0] {
    REG_FRAMES   = 2'd0,
    REG_COLUMNS  = 2'd1,
    REG_CHANNELS = 2'd2,
    REG_HEIGHT   = 2'd3
  } reg_idx_t;

  typedef enum logic {
    PH_PRE  = 1'b0,
    PH_POST = 1'b1
  } phase_t;

  // effective (clamped) configuration as seen by the engine
  typedef struct packed {
    logic [FRAME_BITS-1:0]  frames;
    logic [COLCNT_BITS-1:0] columns;
    logic [CH_FIELD_W-1:0]  channels;
    logic [HEIGHT_BITS-1:0] height;
    logic                   restart;
  } cfg_t;

endpackage

@@ rtl/wcpd_regs.sv @@
// apb configuration registers with clamped copies and image restart
module wcpd_regs #(
  parameter int MAX_CHANNELS = wcpd_pkg::MAX_CHANNELS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [wcpd_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [wcpd_pkg::DATA_BITS-1:0]   pwdata,
  output logic [wcpd_pkg::DATA_BITS-1:0]   prdata,
  output logic                             pready,
  output wcpd_pkg::cfg_t                   cfg
);

  localparam int CW = wcpd_pkg::CH_FIELD_W;
  localparam int DW = wcpd_pkg::DATA_BITS;

  logic [wcpd_pkg::FRAME_BITS-1:0]  raw_frames;
  logic [wcpd_pkg::COLCNT_BITS-1:0] raw_columns;
  logic [wcpd_pkg::CHCNT_BITS-1:0]  raw_channels;
  logic [wcpd_pkg::HEIGHT_BITS-1:0] raw_height;

  logic [wcpd_pkg::FRAME_BITS-1:0]  wr_frames;
  logic [wcpd_pkg::COLCNT_BITS-1:0] wr_columns;
  logic [wcpd_pkg::CHCNT_BITS-1:0]  wr_channels;
  logic [wcpd_pkg::HEIGHT_BITS-1:0] wr_height;

  logic [wcpd_pkg::FRAME_BITS-1:0]  eff_frames;
  logic [wcpd_pkg::COLCNT_BITS-1:0] eff_columns;
  logic [CW-1:0]                    eff_channels;
  logic [wcpd_pkg::HEIGHT_BITS-1:0] eff_height;

  logic               wr_en;
  wcpd_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = wcpd_pkg::reg_idx_t'(paddr[wcpd_pkg::ADDR_BITS-1:2]);

  assign wr_frames   = pwdata[wcpd_pkg::FRAME_BITS-1:0];
  assign wr_columns  = pwdata[wcpd_pkg::COLCNT_BITS-1:0];
  assign wr_channels = pwdata[wcpd_pkg::CHCNT_BITS-1:0];
  assign wr_height   = pwdata[wcpd_pkg::HEIGHT_BITS-1:0];

  // zero acts as one; oversize columns, channels and height clamp
  always_comb begin
    eff_frames = (wr_frames == '0) ? wcpd_pkg::FRAME_BITS'(1) : wr_frames;
    if (wr_columns == '0) begin
      eff_columns = wcpd_pkg::COLCNT_BITS'(1);
    end else if (wr_columns > wcpd_pkg::COLCNT_BITS'(wcpd_pkg::MAX_COLUMNS)) begin
      eff_columns = wcpd_pkg::COLCNT_BITS'(wcpd_pkg::MAX_COLUMNS);
    end else begin
      eff_columns = wr_columns;
    end
    if (wr_channels == '0) begin
      eff_channels = CW'(1);
    end else if (CW'(wr_channels) > CW'(MAX_CHANNELS)) begin
      eff_channels = CW'(MAX_CHANNELS);
    end else begin
      eff_channels = CW'(wr_channels);
    end
    if (wr_height == '0) begin
      eff_height = wcpd_pkg::HEIGHT_BITS'(1);
    end else if (wr_height > wcpd_pkg::HEIGHT_BITS'(wcpd_pkg::MAX_HEIGHT)) begin
      eff_height = wcpd_pkg::HEIGHT_BITS'(wcpd_pkg::MAX_HEIGHT);
    end else begin
      eff_height = wr_height;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_frames   <= wcpd_pkg::FRAMES_RESET;
      raw_columns  <= wcpd_pkg::COLUMNS_RESET;
      raw_channels <= wcpd_pkg::CHANNELS_RESET;
      raw_height   <= wcpd_pkg::HEIGHT_RESET;
      cfg.frames   <= wcpd_pkg::FRAMES_RESET;
      cfg.columns  <= wcpd_pkg::COLUMNS_RESET;
      cfg.channels <= CW'(1);
      cfg.height   <= wcpd_pkg::HEIGHT_RESET;
      cfg.restart  <= 1'b1;
    end else begin
      cfg.restart <= wr_en;
      if (wr_en) begin
        unique case (idx)
          wcpd_pkg::REG_FRAMES: begin
            raw_frames <= wr_frames;
            cfg.frames <= eff_frames;
          end
          wcpd_pkg::REG_COLUMNS: begin
            raw_columns <= wr_columns;
            cfg.columns <= eff_columns;
          end
          wcpd_pkg::REG_CHANNELS: begin
            raw_channels <= wr_channels;
            cfg.channels <= eff_channels;
          end
          wcpd_pkg::REG_HEIGHT: begin
            raw_height <= wr_height;
            cfg.height <= eff_height;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    unique case (idx)
      wcpd_pkg::REG_FRAMES:   prdata = DW'(raw_frames);
      wcpd_pkg::REG_COLUMNS:  prdata = DW'(raw_columns);
      wcpd_pkg::REG_CHANNELS: prdata = DW'(raw_channels);
      wcpd_pkg::REG_HEIGHT:   prdata = DW'(raw_height);
      default:                prdata = '0;
    endcase
  end

endmodule

@@ rtl/wcpd_queue.sv @@
// front end: accepts samples into a short queue ahead of the column engine
module wcpd_queue #(
  parameter int SAMPLE_BITS = wcpd_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  output logic signed [SAMPLE_BITS-1:0] head_sample,
  output logic                          head_valid,
  input  logic                          pop
);

  localparam int QD = wcpd_pkg::QUEUE_DEPTH;
  localparam int QA = $clog2(QD);

  logic signed [SAMPLE_BITS-1:0] store [QD];
  logic [QA-1:0]                 wptr;
  logic [QA-1:0]                 rptr;
  logic [QA:0]                   fill;
  logic                          push;

  assign sample_ready = (fill != (QA+1)'(QD));
  assign head_valid   = (fill != '0);
  assign head_sample  = store[rptr];
  assign push         = sample_valid && sample_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      store[wptr] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QA'(1);
      end
      if (pop) begin
        rptr <= rptr + QA'(1);
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + (QA+1)'(1);
        2'b01:   fill <= fill - (QA+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue popped while empty");
`endif

endmodule

@@ rtl/wcpd_engine.sv @@
// back end: min/max tracking, column closing, y scaling and result register
module wcpd_engine #(
  parameter int SAMPLE_BITS  = wcpd_pkg::SAMPLE_BITS_DEFAULT,
  parameter int COLUMN_BITS  = wcpd_pkg::COLUMN_BITS_DEFAULT,
  parameter int MAX_CHANNELS = wcpd_pkg::MAX_CHANNELS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  wcpd_pkg::cfg_t                  cfg,
  input  logic signed [SAMPLE_BITS-1:0]   head_sample,
  input  logic                            head_valid,
  output logic                            pop,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic [COLUMN_BITS-1:0]          column_index,
  output logic [wcpd_pkg::Y_BITS-1:0]     y_low,
  output logic [wcpd_pkg::Y_BITS-1:0]     y_high,
  output logic                            last_of_run,
  output logic                            image_done
);

  localparam int SB   = SAMPLE_BITS;
  localparam int AW   = wcpd_pkg::ACC_BITS;
  localparam int NW   = wcpd_pkg::COLCNT_BITS;
  localparam int FW   = wcpd_pkg::FRAME_BITS;
  localparam int CW   = wcpd_pkg::CH_FIELD_W;
  localparam int RW   = wcpd_pkg::RUN_CNT_BITS;
  localparam int HW   = wcpd_pkg::HEIGHT_BITS;
  localparam int YW   = wcpd_pkg::Y_BITS;
  localparam int PW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NUMW = HW + SB + 1;

  localparam logic signed [SB-1:0] SAMPLE_MAX  = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SAMPLE_MIN  = {1'b1, {(SB-1){1'b0}}};
  localparam logic [NUMW-1:0]      HALF_ROUND  = NUMW'(1) << (SB - 1);

  wcpd_pkg::phase_t state;
  wcpd_pkg::phase_t state_next;

  logic [NW-1:0]         next_col;
  logic [FW-1:0]         frames_done;
  logic [PW-1:0]         chan_pos;
  logic [AW-1:0]         col_acc;
  logic [AW-1:0]         frame_acc;
  logic signed [SB-1:0]  run_min;
  logic signed [SB-1:0]  run_max;
  logic                  has_data;
  logic [RW-1:0]         run_count;

  // most recent result of the current item, held until we know if it is the last
  logic                  pend_valid;
  logic [NW-1:0]         pend_col;
  logic signed [SB-1:0]  pend_lo;
  logic signed [SB-1:0]  pend_hi;
  logic                  pend_done;

  logic                  slot_free;
  logic                  go;
  logic                  close_cond;
  logic                  post_cond;
  logic                  active;
  logic                  frame_end;
  logic [CW-1:0]         pos_inc;
  logic [AW-1:0]         frame_acc_step;
  logic                  below_limit;
  logic                  cols_left;
  logic                  gen;
  logic                  take;
  logic                  finish;

  function automatic logic [YW-1:0] y_of(input logic signed [SB-1:0] s,
                                         input logic [HW-1:0] h);
    logic [SB-1:0]   off;
    logic [NUMW-1:0] num;
    begin
      // s + 2^(SB-1) is the sample with its sign bit flipped
      off = {~s[SB-1], s[SB-2:0]};
      num = NUMW'(h) * NUMW'(off) + HALF_ROUND;
      y_of = num[SB +: YW];
    end
  endfunction

  assign slot_free      = !result_valid || result_ready;
  assign go             = head_valid && !cfg.restart && !(pend_valid && !slot_free);
  assign below_limit    = run_count < RW'(wcpd_pkg::MAX_RESULTS);
  assign cols_left      = next_col < cfg.columns;
  assign close_cond     = below_limit && cols_left && (col_acc < frame_acc);
  assign frame_acc_step = frame_acc + AW'(cfg.columns);
  assign post_cond      = below_limit && cols_left && (col_acc < frame_acc_step);
  assign active         = cols_left && (frames_done < cfg.frames);
  assign pos_inc        = CW'(chan_pos) + CW'(1);
  assign frame_end      = pos_inc >= cfg.channels;
  assign pop            = finish;

  always_ff @(posedge clk) begin
    if (rst || cfg.restart) begin
      state <= wcpd_pkg::PH_PRE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    gen        = 1'b0;
    take       = 1'b0;
    finish     = 1'b0;
    unique case (state)
      wcpd_pkg::PH_PRE: begin
        if (go) begin
          if (close_cond) begin
            gen = 1'b1;
          end else begin
            take = active;
            if (active && frame_end && post_cond) begin
              state_next = wcpd_pkg::PH_POST;
            end else begin
              finish = 1'b1;
            end
          end
        end
      end
      wcpd_pkg::PH_POST: begin
        if (go) begin
          if (close_cond) begin
            gen = 1'b1;
          end else begin
            finish     = 1'b1;
            state_next = wcpd_pkg::PH_PRE;
          end
        end
      end
      default: begin
        state_next = wcpd_pkg::PH_PRE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_col    <= '0;
      frames_done <= '0;
      chan_pos    <= '0;
      has_data    <= 1'b0;
      run_count   <= '0;
      run_min     <= SAMPLE_MAX;
      run_max     <= SAMPLE_MIN;
    end else if (cfg.restart) begin
      next_col    <= '0;
      frames_done <= '0;
      chan_pos    <= '0;
      has_data    <= 1'b0;
      run_count   <= '0;
      run_min     <= SAMPLE_MAX;
      run_max     <= SAMPLE_MIN;
      col_acc     <= AW'(cfg.frames);
      frame_acc   <= AW'(cfg.columns);
    end else begin
      if (gen) begin
        next_col  <= next_col + NW'(1);
        col_acc   <= col_acc + AW'(cfg.frames);
        run_min   <= SAMPLE_MAX;
        run_max   <= SAMPLE_MIN;
        has_data  <= 1'b0;
        run_count <= run_count + RW'(1);
      end
      if (take) begin
        if (head_sample < run_min) begin
          run_min <= head_sample;
        end
        if (head_sample > run_max) begin
          run_max <= head_sample;
        end
        has_data <= 1'b1;
        if (frame_end) begin
          chan_pos    <= '0;
          frames_done <= frames_done + FW'(1);
          frame_acc   <= frame_acc_step;
        end else begin
          chan_pos <= chan_pos + PW'(1);
        end
      end
      if (finish) begin
        run_count <= '0;
      end
    end
  end

  // pending result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (gen) begin
      pend_valid <= 1'b1;
    end else if (finish) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (gen) begin
      pend_col  <= next_col;
      pend_lo   <= has_data ? run_min : '0;
      pend_hi   <= has_data ? run_max : '0;
      pend_done <= (next_col == cfg.columns - NW'(1));
    end
  end

  // result register, y scaling on the way in
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pend_valid && (gen || finish)) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_valid && (gen || finish)) begin
      column_index <= COLUMN_BITS'(pend_col);
      y_low        <= y_of(pend_lo, cfg.height);
      y_high       <= y_of(pend_hi, cfg.height);
      last_of_run  <= finish;
      image_done   <= pend_done;
    end
  end

`ifndef ASSERT_OFF
  a_run_limit: assert property (@(posedge clk) disable iff (rst)
    run_count <= RW'(wcpd_pkg::MAX_RESULTS))
    else $error("more results than allowed for one transaction");
  a_post_has_item: assert property (@(posedge clk) disable iff (rst)
    (state == wcpd_pkg::PH_POST) |-> head_valid)
    else $error("closing phase without an item in progress");
  a_pend_held: assert property (@(posedge clk) disable iff (rst || cfg.restart)
    (pend_valid && !slot_free) |=> (pend_valid && $stable(pend_col)))
    else $error("pending result lost while output stalled");
  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    !cfg.restart |-> (next_col <= cfg.columns))
    else $error("column counter ran past the column count");
`endif

endmodule

@@ rtl/waveform_column_peak_decimator_unit.sv @@
// top level of the waveform column peak decimator
// Takes one interleaved audio sample per transaction and gives, for every pixel column that
// closes, the column index and the rounded y positions of its minimum and maximum. A sample
// that closes no column is popped without waiting; unless a stalled output holds the engine, a
// steady stream runs at one sample per clock and the engine closes one column per cycle, with a
// closing phase for columns that close at a frame's end. A four-entry sample queue
// in front of the engine and a result register behind it let input and output stall apart.
// Any register write restarts the image; write only while no transaction is in flight.
module waveform_column_peak_decimator_unit #(
  parameter int SAMPLE_BITS  = wcpd_pkg::SAMPLE_BITS_DEFAULT,
  parameter int COLUMN_BITS  = wcpd_pkg::COLUMN_BITS_DEFAULT,
  parameter int MAX_CHANNELS = wcpd_pkg::MAX_CHANNELS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [wcpd_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [wcpd_pkg::DATA_BITS-1:0]  pwdata,
  output logic [wcpd_pkg::DATA_BITS-1:0]  prdata,
  output logic                            pready,
  input  logic signed [SAMPLE_BITS-1:0]   sample,
  input  logic                            sample_valid,
  output logic                            sample_ready,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic [COLUMN_BITS-1:0]          column_index,
  output logic [wcpd_pkg::Y_BITS-1:0]     y_low,
  output logic [wcpd_pkg::Y_BITS-1:0]     y_high,
  output logic                            last_of_run,
  output logic                            image_done
);

  wcpd_pkg::cfg_t                cfg;
  logic signed [SAMPLE_BITS-1:0] head_sample;
  logic                          head_valid;
  logic                          pop;

  wcpd_regs #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_regs (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  wcpd_queue #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_queue (
    .clk         (clk),
    .rst         (rst),
    .sample      (sample),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .head_sample (head_sample),
    .head_valid  (head_valid),
    .pop         (pop)
  );

  wcpd_engine #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COLUMN_BITS (COLUMN_BITS),
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head_sample (head_sample),
    .head_valid  (head_valid),
    .pop         (pop),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .column_index(column_index),
    .y_low       (y_low),
    .y_high      (y_high),
    .last_of_run (last_of_run),
    .image_done  (image_done)
  );

endmodule
